// ===== rtl/dds_tone_generator_assert.svh =====
// ----------------------------------------------------------------------------
// dds_tone_generator_assert.svh
// Assertion macros used by the checker of the tone generator.
// ----------------------------------------------------------------------------
`ifndef DDS_TONE_GENERATOR_ASSERT_SVH
`define DDS_TONE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define DTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tone generator check failed");

// Next-cycle implication, checked only out of reset.
`define DTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tone generator check failed");

`endif

// ===== rtl/dtg_pkg.sv =====
// ----------------------------------------------------------------------------
// dtg_pkg
// Shared widths, register codes, reset values and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtg_pkg;

  localparam int FREQ_W     = 16;
  localparam int SRATE_W    = 18;
  localparam int AMP_W      = 15;
  localparam int CHCNT_W    = 4;
  localparam int FPB_W      = 11;
  localparam int FRAME_W    = 10;
  localparam int PHASE_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int CHAN_OUT_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SRATE_W;
  localparam int MAG_W      = 15;
  localparam int PROD_W     = MAG_W + AMP_W;
  localparam int DVD_W      = FREQ_W + PHASE_W;

  localparam int TABLE_POINTS     = 64;
  localparam int TBL_IDX_W        = $clog2(TABLE_POINTS);
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int MAX_BLOCK_FRAMES = 1024;
  localparam int AMP_FULL         = 32767;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FREQ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHCNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FPB    = 3'd4;

  // Reset values
  localparam int FREQ_RST_I  = 440;
  localparam int SRATE_RST_I = 16000;
  localparam logic [FREQ_W-1:0]  FREQ_RST  = FREQ_W'(FREQ_RST_I);
  localparam logic [SRATE_W-1:0] SRATE_RST = SRATE_W'(SRATE_RST_I);
  localparam logic [AMP_W-1:0]   AMP_RST   = AMP_W'(AMP_FULL);
  localparam logic [CHCNT_W-1:0] CHCNT_RST = 4'd1;
  localparam logic [FPB_W-1:0]   FPB_RST   = 11'd256;
  localparam logic [PHASE_W-1:0] PINC_RST  =
    PHASE_W'((longint'(FREQ_RST_I) << PHASE_W) / longint'(SRATE_RST_I));

  typedef struct packed {
    logic busy;  // division running or result not yet taken
    logic done;  // quotient valid this cycle
  } dtg_div_stat_t;

  // First quadrant of the sine, 64 points, full scale 32767
  function automatic logic [MAG_W-1:0] quarter_wave(input logic [TBL_IDX_W-1:0] idx);
    logic [MAG_W-1:0] v;
    case (idx)
      6'd0:  v = 15'd0;     6'd1:  v = 15'd804;   6'd2:  v = 15'd1608;  6'd3:  v = 15'd2410;
      6'd4:  v = 15'd3212;  6'd5:  v = 15'd4011;  6'd6:  v = 15'd4808;  6'd7:  v = 15'd5602;
      6'd8:  v = 15'd6393;  6'd9:  v = 15'd7179;  6'd10: v = 15'd7962;  6'd11: v = 15'd8739;
      6'd12: v = 15'd9512;  6'd13: v = 15'd10278; 6'd14: v = 15'd11039; 6'd15: v = 15'd11793;
      6'd16: v = 15'd12539; 6'd17: v = 15'd13279; 6'd18: v = 15'd14010; 6'd19: v = 15'd14732;
      6'd20: v = 15'd15446; 6'd21: v = 15'd16151; 6'd22: v = 15'd16846; 6'd23: v = 15'd17530;
      6'd24: v = 15'd18204; 6'd25: v = 15'd18868; 6'd26: v = 15'd19519; 6'd27: v = 15'd20159;
      6'd28: v = 15'd20787; 6'd29: v = 15'd21403; 6'd30: v = 15'd22005; 6'd31: v = 15'd22594;
      6'd32: v = 15'd23170; 6'd33: v = 15'd23731; 6'd34: v = 15'd24279; 6'd35: v = 15'd24811;
      6'd36: v = 15'd25329; 6'd37: v = 15'd25832; 6'd38: v = 15'd26319; 6'd39: v = 15'd26790;
      6'd40: v = 15'd27245; 6'd41: v = 15'd27683; 6'd42: v = 15'd28105; 6'd43: v = 15'd28510;
      6'd44: v = 15'd28898; 6'd45: v = 15'd29268; 6'd46: v = 15'd29621; 6'd47: v = 15'd29956;
      6'd48: v = 15'd30273; 6'd49: v = 15'd30571; 6'd50: v = 15'd30852; 6'd51: v = 15'd31113;
      6'd52: v = 15'd31356; 6'd53: v = 15'd31580; 6'd54: v = 15'd31785; 6'd55: v = 15'd31971;
      6'd56: v = 15'd32137; 6'd57: v = 15'd32285; 6'd58: v = 15'd32412; 6'd59: v = 15'd32521;
      6'd60: v = 15'd32609; 6'd61: v = 15'd32678; 6'd62: v = 15'd32728; 6'd63: v = 15'd32757;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/dtg_div.sv =====
// ----------------------------------------------------------------------------
// dtg_div
// Restoring divider for the phase step: low 16 bits of (freq << 16) / rate,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dtg_pkg::FREQ_W-1:0]    freq,
  input  logic [dtg_pkg::SRATE_W-1:0]   rate,
  output dtg_pkg::dtg_div_stat_t        stat,
  output logic [dtg_pkg::PHASE_W-1:0]   quotient
);
  import dtg_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [SRATE_W-1:0] dvs_r;
  logic [SRATE_W-1:0] rem_r;
  logic [PHASE_W-1:0] quo_r;

  logic [SRATE_W:0]   trial;
  logic               fits;
  logic [SRATE_W-1:0] diff;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign diff  = SRATE_W'(trial - {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(DVD_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {freq, {PHASE_W{1'b0}}};
      dvs_r <= rate;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract where it fits
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= fits ? diff : trial[SRATE_W-1:0];
      quo_r <= {quo_r[PHASE_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r | done_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== rtl/dds_tone_generator.sv =====
// ----------------------------------------------------------------------------
// dds_tone_generator
// A request accepted passes the lookup, product and output registers; its
//   channels then follow one per cycle while the output is not stalled.
// New requests enter while the pipeline has room, also while the output
//   register still sends the channels of an earlier frame.
// A write to a known register stalls input for the pending cycle, the divider
//   steps and loading the step; with a zero rate, for the pending cycle only.
// Reset is synchronous: registers take their defaults, phase step 1802,
//   phase and frame counter zero; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_tone_generator #(
  parameter int MAX_CHANNELS = dtg_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [dtg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dtg_pkg::CFG_DATA_W-1:0]    cfg_data,
  // frame requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_request,
  // channel samples
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dtg_pkg::SAMPLE_W-1:0] out_sample,
  output logic [dtg_pkg::CHAN_OUT_W-1:0]    out_channel,
  output logic                              out_last_of_frame,
  output logic                              out_last_of_block
);
  import dtg_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Configuration registers
  logic [FREQ_W-1:0]  freq_r;
  logic [SRATE_W-1:0] srate_r;
  logic [AMP_W-1:0]   amp_r;
  logic [CHCNT_W-1:0] chcnt_r;
  logic [FPB_W-1:0]   fpb_r;
  logic               pend_r;   // phase step must be recomputed

  // Tone state
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] pinc_r;
  logic [FRAME_W-1:0] frame_r;

  // Pipeline: lookup -> product -> output
  logic               s1_v_r;
  logic [MAG_W-1:0]   s1_mag_r;
  logic               s1_neg_r;
  logic               s1_blk_r;
  logic               s2_v_r;
  logic [PROD_W-1:0]  s2_prod_r;
  logic               s2_neg_r;
  logic               s2_blk_r;
  logic               o_v_r;
  logic [SAMPLE_W-1:0] o_word_r;
  logic               o_blk_r;
  logic [CH_W-1:0]    o_ch_r;

  dtg_div_stat_t      div_stat;
  logic [PHASE_W-1:0] div_quo;
  logic               div_start;

  logic               in_acc;
  logic               frame_go;
  logic               out_acc;
  logic               o_last;
  logic               o_free;
  logic               s2_free;
  logic               s1_free;
  logic [CH_W-1:0]    last_idx;
  logic [FPB_W-1:0]   fpb_eff;
  logic               block_end;
  logic [1:0]         quadrant;
  logic [TBL_IDX_W-1:0] tbl_idx;

  logic [PROD_W:0]    x_sum;
  logic [SAMPLE_W-1:0] q0;
  logic [PROD_W:0]    q0_times;
  logic [PROD_W:0]    rem;
  logic [AMP_W-1:0]   scaled;
  logic [SAMPLE_W-1:0] word;

  // --------------------------------------------------------------------------
  // Configuration: write registers, then recompute the phase step
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= FREQ_RST;
      srate_r <= SRATE_RST;
      amp_r   <= AMP_RST;
      chcnt_r <= CHCNT_RST;
      fpb_r   <= FPB_RST;
      pend_r  <= 1'b0;
    end else begin
      // any known register raises a recompute for one cycle
      pend_r <= cfg_we &&
                (cfg_index inside {REG_FREQ, REG_SRATE, REG_AMP, REG_CHCNT, REG_FPB});
      if (cfg_we) begin
        case (cfg_index)
          REG_FREQ: begin
            freq_r <= cfg_data[FREQ_W-1:0];
          end
          REG_SRATE: begin
            srate_r <= cfg_data[SRATE_W-1:0];
          end
          REG_AMP: begin
            amp_r  <= cfg_data[AMP_W-1:0];
          end
          REG_CHCNT: begin
            chcnt_r <= cfg_data[CHCNT_W-1:0];
          end
          REG_FPB: begin
            fpb_r  <= cfg_data[FPB_W-1:0];
          end
          default: begin
            // unknown index: drop the write
          end
        endcase
      end
    end
  end

  // A zero rate keeps the old step: skip the division
  assign div_start = pend_r && (srate_r != '0);

  dtg_div u_dtg_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .freq     (freq_r),
    .rate     (srate_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // --------------------------------------------------------------------------
  // Handshake and pipeline flow
  // --------------------------------------------------------------------------
  assign out_acc  = o_v_r && !out_stall;
  assign o_last   = (o_ch_r == last_idx);
  assign o_free   = !o_v_r || (out_acc && o_last);
  assign s2_free  = !s2_v_r || o_free;
  assign s1_free  = !s1_v_r || s2_free;

  // Hold input while the phase step is stale or the pipe is full
  assign in_stall = !s1_free || pend_r || div_stat.busy;
  assign in_acc   = in_valid && !in_stall;
  assign frame_go = in_acc && in_request;

  // Clamp the channel count to 1..MAX_CHANNELS, as last channel index
  always_comb begin
    if (chcnt_r == '0) begin
      last_idx = '0;
    end else if (chcnt_r > MAX_CHANNELS) begin
      last_idx = CH_W'(MAX_CHANNELS - 1);
    end else begin
      last_idx = CH_W'(chcnt_r - 1'b1);
    end
  end

  // Clamp frames per block to 1..1024
  always_comb begin
    if (fpb_r == '0) begin
      fpb_eff = FPB_W'(1);
    end else if (fpb_r > FPB_W'(MAX_BLOCK_FRAMES)) begin
      fpb_eff = FPB_W'(MAX_BLOCK_FRAMES);
    end else begin
      fpb_eff = fpb_r;
    end
  end

  assign block_end = ({1'b0, frame_r} + 1'b1) >= fpb_eff;

  // --------------------------------------------------------------------------
  // Phase accumulator and frame counter
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      pinc_r  <= PINC_RST;
      frame_r <= '0;
    end else begin
      if (div_stat.done) begin
        pinc_r <= div_quo;
      end
      if (frame_go) begin
        phase_r <= phase_r + pinc_r;
        frame_r <= block_end ? '0 : frame_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: quarter-wave lookup, reflect by quadrant
  // --------------------------------------------------------------------------
  assign quadrant = phase_r[PHASE_W-1 -: 2];
  assign tbl_idx  = quadrant[0] ? ~phase_r[PHASE_W-3 -: TBL_IDX_W]
                                :  phase_r[PHASE_W-3 -: TBL_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= frame_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_mag_r <= quarter_wave(tbl_idx);
      s1_neg_r <= quadrant[1];
      s1_blk_r <= block_end;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitude times amplitude
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_prod_r <= s1_mag_r * amp_r;
      s2_neg_r  <= s1_neg_r;
      s2_blk_r  <= s1_blk_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: divide by 32767 toward zero, apply sign.
  // The estimate (x + x/32768) / 32768 is never high and at most one low.
  // --------------------------------------------------------------------------
  assign x_sum    = {1'b0, s2_prod_r} + (PROD_W + 1)'(s2_prod_r >> AMP_W);
  assign q0       = SAMPLE_W'(x_sum >> AMP_W);
  assign q0_times = (PROD_W + 1)'({q0, {AMP_W{1'b0}}}) - (PROD_W + 1)'(q0);
  assign rem      = {1'b0, s2_prod_r} - q0_times;
  assign scaled   = AMP_W'(q0 + ((rem >= (PROD_W + 1)'(AMP_FULL)) ? 1'b1 : 1'b0));
  assign word     = s2_neg_r ? SAMPLE_W'(SAMPLE_W'(0) - {1'b0, scaled})
                             : {1'b0, scaled};

  // --------------------------------------------------------------------------
  // Output register: send the frame once per channel
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      o_ch_r <= '0;
    end else if (o_free) begin
      o_v_r  <= s2_v_r;
      o_ch_r <= '0;
    end else if (out_acc) begin
      o_ch_r <= o_ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      o_word_r <= word;
      o_blk_r  <= s2_blk_r;
    end
  end

  assign out_valid         = o_v_r;
  assign out_sample        = o_word_r;
  assign out_channel       = CHAN_OUT_W'(o_ch_r);
  assign out_last_of_frame = o_last;
  assign out_last_of_block = o_last && o_blk_r;

endmodule

// ===== rtl/dtg_checker.sv =====
// ----------------------------------------------------------------------------
// dtg_checker
// Port-level checks on the tone generator's result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dds_tone_generator_assert.svh"

module dtg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [dtg_pkg::SAMPLE_W-1:0] out_sample,
  input logic [dtg_pkg::CHAN_OUT_W-1:0]      out_channel,
  input logic                                out_last_of_frame,
  input logic                                out_last_of_block
);
  import dtg_pkg::*;

  logic mid_frame_acc;
  logic [CHAN_OUT_W-1:0] next_chan;

  assign mid_frame_acc = rst_n && out_valid && !out_stall && !out_last_of_frame;
  assign next_chan     = out_channel + 1'b1;

  // block end only on the last channel
  `DTG_ASSERT_NOW(a_blk_on_last, clk, rst_n, out_valid && out_last_of_block, out_last_of_frame)

  // within a frame, the next channel follows at once
  `DTG_ASSERT_NEXT(a_chan_step, clk, rst_n, mid_frame_acc, out_valid && out_channel == $past(next_chan))

  // every channel of a frame carries the same sample
  `DTG_ASSERT_NEXT(a_same_sample, clk, rst_n, mid_frame_acc, $stable(out_sample))

  // a stalled result holds
  `DTG_ASSERT_NEXT(a_stall_hold, clk, rst_n, rst_n && out_valid && out_stall, out_valid && $stable(out_sample) && $stable(out_channel))

endmodule

bind dds_tone_generator dtg_checker u_dtg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_sample        (out_sample),
  .out_channel       (out_channel),
  .out_last_of_frame (out_last_of_frame),
  .out_last_of_block (out_last_of_block)
);
